// ===== rtl/plid_pkg.sv =====
package plid_pkg;

	localparam int DATA_W       = 32;
	localparam int POS_W        = 5;
	localparam int COUNT_W      = 5;
	localparam int CAPACITY_DEF = 16;

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_BADPOS = 2'd2;

	typedef struct packed {
		logic [1:0]               opcode;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] read_value;
		logic [COUNT_W-1:0]       count;
	} res_t;

	// broadcast command to every cell of the row
	typedef struct packed {
		logic             ins;
		logic             del;
		logic [POS_W-1:0] idx;
	} cell_ctrl_t;

endpackage

// ===== rtl/plid_cell.sv =====
module plid_cell import plid_pkg::*; #(
	parameter int INDEX = 0
) (
	input  logic                     clk,
	input  cell_ctrl_t               ctrl,
	input  logic signed [DATA_W-1:0] value,
	input  logic signed [DATA_W-1:0] left,
	input  logic signed [DATA_W-1:0] right,
	output logic signed [DATA_W-1:0] data,
	output logic                     hit
);

	logic signed [DATA_W-1:0] data_q;
	logic                     at_pos;
	logic                     past_pos;

	// locate this cell relative to the target position
	assign at_pos   = (int'(ctrl.idx) == INDEX);
	assign past_pos = (int'(ctrl.idx) < INDEX);

	// load on insert, take left neighbor past insert point, take right neighbor on delete
	always_ff @(posedge clk) begin
		if (ctrl.ins && at_pos) begin
			data_q <= value;
		end else if (ctrl.ins && past_pos) begin
			data_q <= left;
		end else if (ctrl.del && (at_pos || past_pos)) begin
			data_q <= right;
		end
	end

	assign data = data_q;
	assign hit  = at_pos;

endmodule

// ===== rtl/positional_insert_delete_list_core.sv =====
// A result is registered from its accepted transaction and is valid in the cycle after it is accepted.
// Throughput: one insert, delete or read per cycle; the cell row shifts every
// entry in parallel, so the next transaction is limited only by the result register.
// Reset clears the entry count and the result valid; entry cells are not reset
// and positions beyond the count are never observable.
module positional_insert_delete_list_core import plid_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int XW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	logic [CNT_W-1:0]         count_q;
	logic                     res_valid_q;
	res_t                     res_q;
	logic                     accept;
	logic [XW-1:0]            cnt_ext;
	logic [XW-1:0]            pos_ext;
	logic [XW-1:0]            cnt_next;
	logic                     full;
	logic                     pos_ok_ins;
	logic                     pos_ok_sel;
	logic                     do_ins;
	logic                     do_del;
	logic                     do_rd;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] rd_data;
	cell_ctrl_t               ctrl;
	logic signed [DATA_W-1:0] cell_data [CAPACITY];
	logic [CAPACITY-1:0]      cell_hit;

	// hold input while the result register is stalled
	assign cmd_stall = res_valid_q && res_stall;
	assign accept    = cmd_valid && !cmd_stall;

	// decode the transaction against the current count
	assign cnt_ext    = XW'(count_q);
	assign pos_ext    = XW'(cmd.position);
	assign full       = (cnt_ext == XW'(CAPACITY));
	assign pos_ok_ins = (pos_ext != '0) && (pos_ext <= cnt_ext + XW'(1));
	assign pos_ok_sel = (pos_ext != '0) && (pos_ext <= cnt_ext);

	always_comb begin
		do_ins = 1'b0;
		do_del = 1'b0;
		do_rd  = 1'b0;
		status = ST_BADPOS;
		unique case (cmd.opcode)
			OP_INSERT: begin
				if (full) begin
					status = ST_FULL;
				end else if (pos_ok_ins) begin
					do_ins = 1'b1;
					status = ST_OK;
				end
			end
			OP_DELETE: begin
				if (pos_ok_sel) begin
					do_del = 1'b1;
					status = ST_OK;
				end
			end
			OP_READ: begin
				if (pos_ok_sel) begin
					do_rd  = 1'b1;
					status = ST_OK;
				end
			end
			default: status = ST_BADPOS;
		endcase
	end

	always_comb begin
		cnt_next = cnt_ext;
		if (do_ins) begin
			cnt_next = cnt_ext + XW'(1);
		end else if (do_del) begin
			cnt_next = cnt_ext - XW'(1);
		end
	end

	// broadcast the command to the cell row
	assign ctrl.ins = accept && do_ins;
	assign ctrl.del = accept && do_del;
	assign ctrl.idx = cmd.position - POS_W'(1);

	// row of entry cells linked to neighbors; ends see cmd value (left), zero (right)
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_d;
		logic signed [DATA_W-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = cmd.value;
		end else begin : g_left
			assign left_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_right
			assign right_d = cell_data[i+1];
		end
		plid_cell #(
			.INDEX(i)
		) u_cell (
			.clk  (clk),
			.ctrl (ctrl),
			.value(cmd.value),
			.left (left_d),
			.right(right_d),
			.data (cell_data[i]),
			.hit  (cell_hit[i])
		);
	end

	// select the addressed cell for a read
	always_comb begin
		rd_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (cell_hit[i]) begin
				rd_data = rd_data | cell_data[i];
			end
		end
	end

	// advance the entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= CNT_W'(cnt_next);
		end
	end

	// hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!cmd_stall) begin
			res_valid_q <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.status     <= status;
			res_q.read_value <= do_rd ? rd_data : '0;
			res_q.count      <= COUNT_W'(cnt_next);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
